// ----- hw/rtl/deferred_write_coalescer_defines.svh -----
// assertion macros for the deferred write coalescer
// expects aclk and aresetn in the scope of each use; no other dependencies
`ifndef DEFERRED_WRITE_COALESCER_DEFINES_SVH
`define DEFERRED_WRITE_COALESCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DWC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dwc_pkg.sv -----
// shared types, constants and helper functions of the deferred write coalescer
// no dependencies
package dwc_pkg;

    // sizing
    localparam int SLOTS_DEF = 4;
    localparam int MAX_OUT   = 4;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int QPTR_W    = $clog2(MAX_OUT);
    localparam int PADDR_W   = 3;

    // register map, index taken from paddr[PADDR_W-1]
    localparam logic REG_IDX_DELAY = 1'b0;
    localparam logic [15:0] DELAY_RESET = 16'd400;

    // item kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // write sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // key that is never held
    localparam logic [15:0] KEY_BYPASS = 16'h0000;

    typedef struct packed {
        logic        kind;
        logic [15:0] key;
        logic [1:0]  size;
        logic [15:0] address;
        logic [31:0] value;
    } item_t;

    typedef struct packed {
        logic [15:0] address;
        logic [31:0] value;
        logic [1:0]  size;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        result_t [MAX_OUT-1:0]     res;
    } batch_t;

    typedef struct packed {
        logic             empty;
        logic [CNT_W-1:0] count;
    } oq_status_t;

    // size code three acts as a word
    function automatic logic [1:0] clamp_size(input logic [1:0] s);
        return (s > SIZE_WORD) ? SIZE_WORD : s;
    endfunction

    function automatic logic [31:0] mask_value(input logic [31:0] v, input logic [1:0] s);
        logic [31:0] r;
        case (s)
            SIZE_BYTE: r = {24'h0, v[7:0]};
            SIZE_HALF: r = {16'h0, v[15:0]};
            default:   r = v;
        endcase
        return r;
    endfunction

    // a delay of zero acts as one tick
    function automatic logic [15:0] load_delay(input logic [15:0] d);
        return (d == 16'd0) ? 16'd1 : d;
    endfunction

endpackage

// ----- hw/rtl/dwc_slots.sv -----
// pending write slots: key match, lowest free slot, tick countdown and expiry batch
// depends on dwc_pkg
module dwc_slots #(
    parameter int SLOTS = dwc_pkg::SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  dwc_pkg::item_t      item,
    input  logic [15:0]         delay_ticks,
    output dwc_pkg::batch_t     batch
);

    localparam int RANK_W = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] used_reg, used_next;
    logic [15:0] key_reg  [SLOTS];
    logic [15:0] key_next [SLOTS];
    logic [15:0] addr_reg  [SLOTS];
    logic [15:0] addr_next [SLOTS];
    logic [1:0]  size_reg  [SLOTS];
    logic [1:0]  size_next [SLOTS];
    logic [31:0] data_reg  [SLOTS];
    logic [31:0] data_next [SLOTS];
    logic [15:0] cd_reg  [SLOTS];
    logic [15:0] cd_next [SLOTS];

    logic [15:0]       cd_dec [SLOTS];
    logic [RANK_W-1:0] rank   [SLOTS];
    logic [SLOTS-1:0]  expired, emit, match, first_free;
    logic              has_match, has_free, key_zero, bypass;
    logic [1:0]        in_size;
    logic [15:0]       load_cd;

    // per-slot lookup and expiry; lowest free slot and expiry rank look across all slots
    always_comb begin
        logic [SLOTS-1:0] lowm;
        in_size = dwc_pkg::clamp_size(item.size);
        load_cd = dwc_pkg::load_delay(delay_ticks);
        for (int i = 0; i < SLOTS; i++) begin
            lowm          = (SLOTS'(1) << i) - SLOTS'(1);
            cd_dec[i]     = (cd_reg[i] != 16'd0) ? (cd_reg[i] - 16'd1) : cd_reg[i];
            expired[i]    = used_reg[i] && (cd_dec[i] == 16'd0);
            match[i]      = used_reg[i] && (key_reg[i] == item.key);
            first_free[i] = !used_reg[i] && ((~used_reg & lowm) == '0);
            rank[i]       = RANK_W'($countones(expired & lowm));
            emit[i]       = expired[i] && (int'(rank[i]) < dwc_pkg::MAX_OUT);
        end
        has_match = |match;
        has_free  = |first_free;
        key_zero  = (item.key == dwc_pkg::KEY_BYPASS);
        bypass    = key_zero || (!has_match && !has_free);
    end

    // slot state update
    always_comb begin
        used_next = used_reg;
        key_next  = key_reg;
        addr_next = addr_reg;
        size_next = size_reg;
        data_next = data_reg;
        cd_next   = cd_reg;
        if (fire) begin
            if (item.kind == dwc_pkg::KIND_TICK) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (used_reg[i]) begin
                        cd_next[i] = cd_dec[i];
                    end
                    if (emit[i]) begin
                        used_next[i] = 1'b0;
                    end
                end
            end else if (!key_zero) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (match[i]) begin
                        // coalesce: address and size keep the first capture
                        data_next[i] = item.value;
                        cd_next[i]   = load_cd;
                    end else if (!has_match && first_free[i]) begin
                        used_next[i] = 1'b1;
                        key_next[i]  = item.key;
                        addr_next[i] = item.address;
                        size_next[i] = in_size;
                        data_next[i] = item.value;
                        cd_next[i]   = load_cd;
                    end
                end
            end
        end
    end

    // results of the item, in slot order
    always_comb begin
        batch = '0;
        if (item.kind == dwc_pkg::KIND_TICK) begin
            batch.count = dwc_pkg::CNT_W'($countones(emit));
            for (int j = 0; j < dwc_pkg::MAX_OUT; j++) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (emit[i] && (int'(rank[i]) == j)) begin
                        batch.res[j].address = addr_reg[i];
                        batch.res[j].value   = dwc_pkg::mask_value(data_reg[i], size_reg[i]);
                        batch.res[j].size    = size_reg[i];
                    end
                end
            end
        end else if (bypass) begin
            // write straight through
            batch.count          = dwc_pkg::CNT_W'(1);
            batch.res[0].address = item.address;
            batch.res[0].value   = dwc_pkg::mask_value(item.value, in_size);
            batch.res[0].size    = in_size;
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    // slot payload
    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        data_reg <= data_next;
        cd_reg   <= cd_next;
    end

endmodule

// ----- hw/rtl/dwc_outq.sv -----
// result queue: loads one item's whole batch, sends it one beat per cycle while m_tready is high
// depends on dwc_pkg
module dwc_outq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  dwc_pkg::batch_t      batch,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output dwc_pkg::result_t     m_res,
    output logic                 m_tlast,
    output dwc_pkg::oq_status_t  status
);

    dwc_pkg::result_t q_reg  [dwc_pkg::MAX_OUT];
    dwc_pkg::result_t q_next [dwc_pkg::MAX_OUT];
    logic [dwc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [dwc_pkg::QPTR_W-1:0] ptr_reg, ptr_next;

    // head of queue drives the port
    always_comb begin
        m_tvalid      = (cnt_reg != '0);
        m_tlast       = (cnt_reg == dwc_pkg::CNT_W'(1));
        m_res         = q_reg[ptr_reg];
        status.empty  = (cnt_reg == '0);
        status.count  = cnt_reg;
    end

    // load or drain
    always_comb begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        q_next   = q_reg;
        if (load) begin
            cnt_next = batch.count;
            ptr_next = '0;
            for (int j = 0; j < dwc_pkg::MAX_OUT; j++) begin
                q_next[j] = batch.res[j];
            end
        end else if (m_tvalid && m_tready) begin
            cnt_next = cnt_reg - dwc_pkg::CNT_W'(1);
            ptr_next = ptr_reg + dwc_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule

// ----- hw/rtl/deferred_write_coalescer.sv -----
// deferred write coalescer top: input register, config register, slots and result queue
// depends on dwc_pkg, dwc_slots, dwc_outq and deferred_write_coalescer_defines.svh
//
//   port group  | direction | carries
//   s_*         | in        | update or tick beat (tuser = kind)
//   m_*         | out       | issued write beat (tlast = last write of the item)
//   apb         | in/out    | delay_ticks at byte address 0
//
// an accepted beat is held in the input register; its slot work is done in the cycle
// the result queue is empty, and all its writes (0 to 4) load the result queue at once
// the queue sends one write per cycle while m_tready is high;
// the next item waits in the input register until the queue is empty
// synchronous active-low reset clears slot occupancy, the input register valid bit and the queue,
// and loads the delay register with 400; no clearing pass
`include "deferred_write_coalescer_defines.svh"

module deferred_write_coalescer #(
    parameter int SLOTS = dwc_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // key [15:0], size_code [17:16], address [33:18], value [65:34], zero pad [71:66]
    input  logic [71:0]                 s_tdata,
    // kind [0]
    input  logic                        s_tuser,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // write_address [15:0], write_value [47:16], write_size [49:48], zero pad [55:50]
    output logic [55:0]                 m_tdata,
    output logic                        m_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dwc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic                in_valid_reg, in_valid_next;
    dwc_pkg::item_t      item_reg, item_next;
    logic [15:0]         delay_reg, delay_next;
    logic                fire, cfg_wr;
    dwc_pkg::batch_t     batch;
    dwc_pkg::result_t    m_res;
    dwc_pkg::oq_status_t oq_status;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        delay_next = delay_reg;
        if (cfg_wr && (paddr[dwc_pkg::PADDR_W-1] == dwc_pkg::REG_IDX_DELAY)) begin
            delay_next = pwdata[15:0];
        end
        prdata = '0;
        if (paddr[dwc_pkg::PADDR_W-1] == dwc_pkg::REG_IDX_DELAY) begin
            prdata = {16'h0, delay_reg};
        end
    end

    // input register, freed when its item is processed
    assign fire     = in_valid_reg && oq_status.empty;
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next    = 1'b1;
            item_next.kind    = s_tuser;
            item_next.key     = s_tdata[15:0];
            item_next.size    = s_tdata[17:16];
            item_next.address = s_tdata[33:18];
            item_next.value   = s_tdata[65:34];
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            delay_reg    <= dwc_pkg::DELAY_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            delay_reg    <= delay_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    dwc_slots #(
        .SLOTS (SLOTS)
    ) u_slots (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (item_reg),
        .delay_ticks (delay_reg),
        .batch       (batch)
    );

    dwc_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .batch    (batch),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res),
        .m_tlast  (m_tlast),
        .status   (oq_status)
    );

    // result beat packing
    assign m_tdata = {6'h0, m_res.size, m_res.value, m_res.address};

    // checks
    `DWC_ASSERT_NXT(a_in_hold, in_valid_reg && !oq_status.empty, in_valid_reg, "pending beat lost while results drain")
    `DWC_ASSERT_NXT(a_run_cont, m_tvalid && m_tready && !m_tlast, m_tvalid, "write run ended without last")
    `DWC_ASSERT_NXT(a_upd_one, fire && (item_reg.kind == dwc_pkg::KIND_UPDATE), oq_status.count < 2, "update gave more than one write")
    `DWC_ASSERT_IMP(a_batch_cap, fire, int'(batch.count) <= dwc_pkg::MAX_OUT, "tick batch over limit")

endmodule
